@@ hdl/fnv1a_word_hash_top_defines.svh @@
// assertion macros for the word hash block
// used by fwh_back, which checks its own sequencing; needs clk and rst in scope
`ifndef FNV1A_WORD_HASH_TOP_DEFINES_SVH
`define FNV1A_WORD_HASH_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define FWH_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("fwh check failed");

// consequence holds in the cycle after the antecedent
`define FWH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fwh sequencing check failed");

`endif

@@ hdl/fwh_pkg.sv @@
// shared types, the offset basis constant and the mixing function of the word hash block
// no dependencies
`default_nettype none

package fwh_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  typedef struct packed {
    logic [63:0] word;
    logic        full;
    logic [2:0]  short_len;
    logic        last;
    logic        pal;
    logic [31:0] crc;
  } fwh_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BYTES,
    ST_PAL,
    ST_FIN
  } fwh_state_t;

  // (h ^ v) * 0x100000001B3 as shift and add: 2^40 + 0x1b3
  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [63:0] v);
    logic [63:0] x;
    x = h ^ v;
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

`default_nettype wire

@@ hdl/fwh_front.sv @@
// input side: takes words from the source and sorts them into full or short items
// depends on fwh_pkg; feeds fwh_queue
`default_nettype none

module fwh_front (
  input  wire logic               data_valid,
  output logic                    data_stall,
  input  wire logic [63:0]        data_word,
  input  wire logic [3:0]         byte_count,
  input  wire logic               last,
  input  wire logic               palette_flag,
  input  wire logic [31:0]        palette_checksum,
  input  wire logic               q_full,
  output logic                    q_push,
  output fwh_pkg::fwh_entry_t     q_entry
);
  import fwh_pkg::*;

  assign data_stall = q_full;
  assign q_push     = data_valid && !q_full;

  always_comb begin
    q_entry.word      = data_word;
    // counts of eight and above take the whole word
    q_entry.full      = byte_count[3];
    q_entry.short_len = byte_count[2:0];
    q_entry.last      = last;
    q_entry.pal       = last && palette_flag;
    q_entry.crc       = palette_checksum;
  end

endmodule

`default_nettype wire

@@ hdl/fwh_queue.sv @@
// short queue between the input side and the hashing sequencer
// depends on fwh_pkg
`default_nettype none

module fwh_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire fwh_pkg::fwh_entry_t wr_entry,
  output logic                    full,
  output logic                    rd_valid,
  input  wire logic               pop,
  output fwh_pkg::fwh_entry_t     rd_entry
);
  import fwh_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fwh_entry_t      entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/fwh_back.sv @@
// hashing sequencer: mixes words or single bytes, the palette crc, and drives the digest
// depends on fwh_pkg and fnv1a_word_hash_top_defines.svh
`default_nettype none

`include "fnv1a_word_hash_top_defines.svh"

module fwh_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire fwh_pkg::fwh_entry_t q_entry,
  output logic                    digest_valid,
  input  wire logic               digest_stall,
  output logic [63:0]             digest
);
  import fwh_pkg::*;

  fwh_state_t  state;
  fwh_state_t  state_next;
  logic [63:0] hash;
  logic [63:0] hash_next;
  logic [55:0] shreg;
  logic [55:0] shreg_next;
  logic [2:0]  rem;
  logic [2:0]  rem_next;
  logic        last_r;
  logic        last_r_next;
  logic        pal_r;
  logic        pal_r_next;
  logic [31:0] crc_r;
  logic [31:0] crc_r_next;
  logic        fin_go;
  logic        digest_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      hash         <= FNV_BASIS;
      digest_valid <= 1'b0;
    end else begin
      state        <= state_next;
      hash         <= hash_next;
      digest_valid <= digest_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg  <= shreg_next;
    rem    <= rem_next;
    last_r <= last_r_next;
    pal_r  <= pal_r_next;
    crc_r  <= crc_r_next;
    if (fin_go) begin
      digest <= hash;
    end
  end

  always_comb begin
    state_next  = state;
    hash_next   = hash;
    shreg_next  = shreg;
    rem_next    = rem;
    last_r_next = last_r;
    pal_r_next  = pal_r;
    crc_r_next  = crc_r;
    q_pop       = 1'b0;
    fin_go      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          last_r_next = q_entry.last;
          pal_r_next  = q_entry.pal;
          crc_r_next  = q_entry.crc;
          shreg_next  = q_entry.word[55:0];
          rem_next    = q_entry.short_len;
          if (q_entry.full) begin
            hash_next = fnv_mix(hash, q_entry.word);
          end
          if (!q_entry.full && (q_entry.short_len != 3'd0)) begin
            state_next = ST_BYTES;
          end else if (q_entry.last) begin
            state_next = q_entry.pal ? ST_PAL : ST_FIN;
          end
        end
      end
      ST_BYTES: begin
        hash_next  = fnv_mix(hash, {56'd0, shreg[7:0]});
        shreg_next = shreg >> 8;
        rem_next   = rem - 3'd1;
        if (rem == 3'd1) begin
          if (last_r) begin
            state_next = pal_r ? ST_PAL : ST_FIN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PAL: begin
        hash_next  = fnv_mix(hash, {32'd0, crc_r});
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!digest_valid || !digest_stall) begin
          fin_go     = 1'b1;
          hash_next  = FNV_BASIS;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign digest_valid_next = fin_go || (digest_valid && digest_stall);

  `FWH_ASSERT(a_rem_live, (state != ST_BYTES) || (rem != 3'd0))
  `FWH_ASSERT_NEXT(a_fin_hold, (state == ST_FIN) && digest_valid && digest_stall, state == ST_FIN)
  `FWH_ASSERT_NEXT(a_reload, fin_go, (hash == FNV_BASIS) && digest_valid)

endmodule

`default_nettype wire

@@ hdl/fnv1a_word_hash_top.sv @@
// word-wide fnv-1a 64 hash: full words one per cycle, short tails one byte per cycle,
// while a held digest does not keep the sequencer waiting in its final state
// the full-word rate is limited by the one-mix-per-cycle hash register loop; no new item
// is popped until the last one's tail bytes and palette crc are mixed and its digest registered
// reset: synchronous, active high; hash reloads the offset basis, queue and digest empty
// depends on fwh_pkg, fwh_front, fwh_queue, fwh_back
`default_nettype none

module fnv1a_word_hash_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        data_valid,
  output logic             data_stall,
  input  wire logic [63:0] data_word,
  input  wire logic [3:0]  byte_count,
  input  wire logic        last,
  input  wire logic        palette_flag,
  input  wire logic [31:0] palette_checksum,
  output logic             digest_valid,
  input  wire logic        digest_stall,
  output logic [63:0]      digest
);
  import fwh_pkg::*;

  fwh_entry_t push_entry;
  fwh_entry_t pop_entry;
  logic       q_full;
  logic       q_push;
  logic       q_valid;
  logic       q_pop;

  fwh_front u_front (
    .data_valid       (data_valid),
    .data_stall       (data_stall),
    .data_word        (data_word),
    .byte_count       (byte_count),
    .last             (last),
    .palette_flag     (palette_flag),
    .palette_checksum (palette_checksum),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (push_entry)
  );

  fwh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (push_entry),
    .full     (q_full),
    .rd_valid (q_valid),
    .pop      (q_pop),
    .rd_entry (pop_entry)
  );

  fwh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_entry      (pop_entry),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// testbench for fnv1a_word_hash_top: drives random and directed word streams and
// checks every digest against a scoreboard that keeps its own copy of the hash
// needs only the block under test, no package or file
`timescale 1ns / 100ps

module tb;

  localparam logic [63:0] HASH_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] HASH_PRIME = 64'h0000_0100_0000_01B3;
  localparam int RANDOM_WORDS = 1900;
  localparam int CYCLE_LIMIT = 400000;

  class fnv_digest_tracker;
    logic [63:0] running_hash;
    logic [63:0] pending_digests[$];
    int mismatches;
    int digests_checked;

    function new();
      running_hash = HASH_BASIS;
      mismatches = 0;
      digests_checked = 0;
    endfunction

    function logic [63:0] stir(logic [63:0] h, logic [63:0] v);
      return (h ^ v) * HASH_PRIME;
    endfunction

    function void absorb_word(logic [63:0] word, logic [3:0] count, logic is_last,
                              logic pal, logic [31:0] crc);
      logic [63:0] h;
      int i;
      h = running_hash;
      if (count >= 4'd8) begin
        h = stir(h, word);
      end else begin
        for (i = 0; i < count; i++) h = stir(h, {56'b0, word[8*i +: 8]});
      end
      if (!is_last) begin
        running_hash = h;
        return;
      end
      if (pal) h = stir(h, {32'b0, crc});
      pending_digests.push_back(h);
      running_hash = HASH_BASIS;
    endfunction

    function void check_digest(logic [63:0] got);
      logic [63:0] want;
      if (pending_digests.size() == 0) begin
        $error("digest: none expected, actual %h", got);
        mismatches++;
        return;
      end
      want = pending_digests.pop_front();
      digests_checked++;
      if (got !== want) begin
        $error("digest: expected %h, actual %h", want, got);
        mismatches++;
      end
    endfunction

    function int pending_count();
      return pending_digests.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        data_valid;
  logic        data_stall;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last;
  logic        palette_flag;
  logic [31:0] palette_checksum;
  logic        digest_valid;
  logic        digest_stall;
  logic [63:0] digest;

  fnv_digest_tracker tracker = new();
  bit calm;
  int words_sent;
  int messages_sent;
  int palettes_sent;
  int tails_sent;
  int cycles;

  fnv1a_word_hash_top dut (
    .clk              (clk),
    .rst              (rst),
    .data_valid       (data_valid),
    .data_stall       (data_stall),
    .data_word        (data_word),
    .byte_count       (byte_count),
    .last             (last),
    .palette_flag     (palette_flag),
    .palette_checksum (palette_checksum),
    .digest_valid     (digest_valid),
    .digest_stall     (digest_stall),
    .digest           (digest)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("run timed out with %0d digests outstanding", tracker.pending_count());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(logic [63:0] word, logic [3:0] count, logic is_last,
                           logic pal, logic [31:0] crc);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk);
      data_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    data_valid = 1'b1;
    data_word = word;
    byte_count = count;
    last = is_last;
    palette_flag = pal;
    palette_checksum = crc;
    do @(posedge clk); while (data_stall);
    tracker.absorb_word(word, count, is_last, pal, crc);
    words_sent++;
    if (count < 4'd8) tails_sent++;
    if (is_last) begin
      messages_sent++;
      if (pal) palettes_sent++;
    end
  endtask

  task automatic send_random_message();
    int len;
    int k;
    bit tidy;
    logic is_last;
    logic [3:0] cnt;
    tidy = ($urandom_range(0, 99) < 85);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
    calm = ($urandom_range(0, 5) == 0);
    for (k = 0; k < len; k++) begin
      is_last = (k == len - 1);
      if (tidy) begin
        cnt = is_last ? 4'($urandom_range(0, 8)) : 4'd8;
        if (cnt == 4'd8 && $urandom_range(0, 15) == 0) cnt = 4'($urandom_range(9, 15));
      end else begin
        cnt = 4'($urandom_range(0, 15));
      end
      send_word(rand64(), cnt, is_last, 1'($urandom_range(0, 1)), $urandom);
    end
  endtask

  // receiving side: after each digest is taken, stall the next one for a randomly drawn gap
  initial begin : digest_sink
    int hold;
    hold = 0;
    digest_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && digest_valid) begin
        if (!digest_stall) begin
          tracker.check_digest(digest);
          hold = draw_gap();
        end else if (hold > 0) begin
          hold--;
        end
      end
      @(negedge clk);
      digest_stall = (hold > 0);
    end
  end

  initial begin : stimulus
    int n;
    calm = 1'b0;
    words_sent = 0;
    messages_sent = 0;
    palettes_sent = 0;
    tails_sent = 0;
    rst = 1'b1;
    data_valid = 1'b0;
    data_word = '0;
    byte_count = '0;
    last = 1'b0;
    palette_flag = 1'b0;
    palette_checksum = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty messages, with and without palette
    send_word(rand64(), 4'd0, 1'b1, 1'b0, $urandom);
    send_word(rand64(), 4'd0, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // extreme whole words
    send_word({64{1'b1}}, 4'd8, 1'b1, 1'b0, 32'h0);
    send_word(64'h0, 4'd8, 1'b1, 1'b1, 32'h0);
    // every short tail length, garbage above the valid bytes
    for (n = 1; n < 8; n++) send_word(rand64(), 4'(n), 1'b1, 1'(n == 5), $urandom);
    // counts above eight saturate to a whole word
    send_word(rand64(), 4'd9, 1'b1, 1'b0, 32'h0);
    send_word(rand64(), 4'd15, 1'b1, 1'b1, $urandom);
    // short word in mid message
    send_word(rand64(), 4'd3, 1'b0, 1'b0, 32'h0);
    send_word(rand64(), 4'd8, 1'b1, 1'b0, 32'h0);
    // palette fields on a non-final word are ignored
    send_word(rand64(), 4'd8, 1'b0, 1'b1, $urandom);
    send_word(rand64(), 4'd8, 1'b1, 1'b0, $urandom);
    // empty word in mid message
    send_word(rand64(), 4'd0, 1'b0, 1'b1, $urandom);
    send_word(rand64(), 4'd4, 1'b1, 1'b1, $urandom);
    // longer message ending in a tail and palette
    for (n = 0; n < 3; n++) send_word(rand64(), 4'd8, 1'b0, 1'b0, 32'h0);
    send_word(rand64(), 4'd5, 1'b1, 1'b1, 32'hFFFF_FFFF);

    while (words_sent < RANDOM_WORDS) send_random_message();

    @(negedge clk);
    data_valid = 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("covered %0d words in %0d messages (%0d short, %0d with palette)",
             words_sent, messages_sent, tails_sent, palettes_sent);
    $display("%0d digests checked, %0d mismatches", tracker.digests_checked,
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ fnv1a_word_hash_top.f @@
+incdir+hdl
hdl/fwh_pkg.sv
hdl/fwh_front.sv
hdl/fwh_queue.sv
hdl/fwh_back.sv
hdl/fnv1a_word_hash_top.sv
sim/tb.sv
